// File: rtl/core/tilt_pkg.sv
// Shared types, constants and the arctangent step table for the tilt angle core.
// Depends on nothing; the channel interfaces and the core in rtl/core import it.
`timescale 1ns / 1ps

package tilt_pkg;

   localparam int SAMPLE_W     = 12;
   localparam int CFG_W        = 18;
   localparam int ANGLE_W      = 16;
   localparam int DEF_WINDOW   = 25;
   localparam int PRESHIFT     = 12;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int ACC_W        = 21;
   localparam int ROUND_BITS   = 4;
   localparam int ANGLE_LIMIT  = 23040;

   localparam logic [CFG_W-1:0]        CENTER_RESET = CFG_W'(51175);
   localparam logic signed [ACC_W-1:0] QUARTER_TURN = ACC_W'(184318);

   // Axis tag carried with each sample.
   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SETUP,
      ST_ROTATE,
      ST_FINISH
   } tilt_state_type;

   // atan(2^-i) in 1/2048 degree.
   function automatic acc_type atan_entry(input logic [STEP_W-1:0] step);
      acc_type val;
      case (step)
         4'd0:    val = ACC_W'(92159);
         4'd1:    val = ACC_W'(54404);
         4'd2:    val = ACC_W'(28746);
         4'd3:    val = ACC_W'(14592);
         4'd4:    val = ACC_W'(7324);
         4'd5:    val = ACC_W'(3666);
         4'd6:    val = ACC_W'(1833);
         4'd7:    val = ACC_W'(917);
         4'd8:    val = ACC_W'(458);
         4'd9:    val = ACC_W'(229);
         4'd10:   val = ACC_W'(115);
         4'd11:   val = ACC_W'(57);
         4'd12:   val = ACC_W'(29);
         4'd13:   val = ACC_W'(14);
         4'd14:   val = ACC_W'(7);
         default: val = ACC_W'(4);
      endcase
      return val;
   endfunction

endpackage

// File: rtl/core/tilt_req_if.sv
// Sample channel: valid/ready plus the axis tag and the 12-bit sample.
// Depends on tilt_pkg.
`timescale 1ns / 1ps

interface tilt_req_if;
   import tilt_pkg::*;

   logic                valid;
   logic                ready;
   logic                req_type;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output req_type, output sample, input ready);
   modport sink   (input valid, input req_type, input sample, output ready);
endinterface

// File: rtl/core/tilt_rsp_if.sv
// Angle channel: valid/ready plus the signed tilt angle.
// Depends on tilt_pkg.
`timescale 1ns / 1ps

interface tilt_rsp_if;
   import tilt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

// File: rtl/core/tilt_csr_if.sv
// Configuration write channel: valid/ready plus the center offset value.
// Depends on tilt_pkg.
`timescale 1ns / 1ps

interface tilt_csr_if;
   import tilt_pkg::*;

   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] center_offset;

   modport source (output valid, output center_offset, input ready);
   modport sink   (input valid, input center_offset, output ready);
endinterface

// File: rtl/core/tilt_angle_from_window_sums_core.sv
// Tilt angle core: windowed accelerometer sums, then a CORDIC arctangent.
// Depends on tilt_pkg, the tilt_*_if channel interfaces and tilt_ram.
`timescale 1ns / 1ps

// Usage
// The req_chan channel carries one accelerometer sample per beat, tagged X
// (req_type = 0) or Y (req_type = 1). Each sample replaces the entry at the
// current slot of its axis ring and updates that axis's running sum; only a
// Y sample advances the slot. When the slot wraps after WINDOW Y samples,
// one angle beat leaves on rsp_chan: 57.295 * atan2(center - x_sum,
// center - y_sum) in 1/128 degree, rounded and limited to +-23040.
// The csr_chan channel writes center_offset; it is always ready and should
// be written only while no sample is in flight.
// Timing: a sample that does not wrap the window is accepted in ST_IDLE,
// then gets its ring read-modify-write in ST_UPDATE; req_chan is ready only
// in ST_IDLE, so no new sample is taken until the last one is through.
// A wrapping Y sample then forms the differences in ST_SETUP, runs the 16
// CORDIC iterations in ST_ROTATE (one shared shift-add unit, one step per cycle)
// and is rounded in ST_FINISH. The angle sits in an output register, so new
// samples are taken while it waits; a second angle that finishes before the
// first is taken stalls the core until rsp_chan.ready frees the register.
// Reset (synchronous, active high) clears sums, slot and ring valid bits so
// the rings read as zero, and loads center_offset with 51175.

module tilt_angle_from_window_sums_core #(
   parameter int WINDOW = tilt_pkg::DEF_WINDOW
) (
   input  logic       clock,
   input  logic       reset,
   tilt_req_if.sink   req_chan,
   tilt_rsp_if.source rsp_chan,
   tilt_csr_if.sink   csr_chan
);
   import tilt_pkg::*;

   localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W    = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
   localparam int DIFF_W   = ((CFG_W > SUM_W) ? CFG_W : SUM_W) + 1;
   // Room for the pre-shift, the CORDIC gain and the diagonal magnitude.
   localparam int CORDIC_W = DIFF_W + PRESHIFT + 3;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

   // Control and datapath registers.
   tilt_state_type             state_ff, state_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic [SUM_W-1:0]           x_sum_ff, x_sum_in;
   logic [SUM_W-1:0]           y_sum_ff, y_sum_in;
   logic [WINDOW-1:0]          x_vld_ff, x_vld_in;
   logic [WINDOW-1:0]          y_vld_ff, y_vld_in;
   logic [CFG_W-1:0]           center_ff, center_in;
   logic                       kind_ff, kind_in;
   logic [SAMPLE_W-1:0]        sample_ff, sample_in;
   logic signed [CORDIC_W-1:0] cx_ff, cx_in;
   logic signed [CORDIC_W-1:0] cy_ff, cy_in;
   acc_type                    acc_ff, acc_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       zero_ff, zero_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_W-1:0]  angle_ff, angle_in;

   // Decoded controls.
   logic req_ready;
   logic req_accept;
   logic x_wr_en;
   logic y_wr_en;
   logic load_rsp;

   // Ring memories.
   logic [SAMPLE_W-1:0] x_rd_data;
   logic [SAMPLE_W-1:0] y_rd_data;
   logic [SAMPLE_W-1:0] old_x;
   logic [SAMPLE_W-1:0] old_y;

   // Setup, CORDIC and rounding terms.
   logic signed [DIFF_W-1:0]   num_diff;
   logic signed [DIFF_W-1:0]   den_diff;
   logic signed [CORDIC_W-1:0] num_wide;
   logic signed [CORDIC_W-1:0] den_wide;
   logic signed [CORDIC_W-1:0] x_shift;
   logic signed [CORDIC_W-1:0] y_shift;
   logic                       y_positive;
   logic [ACC_W-1:0]           acc_mag;
   logic [ACC_W-1:0]           q_mag;
   logic [ANGLE_W-1:0]         q_sat;
   logic signed [ANGLE_W-1:0]  angle_rounded;

   assign req_accept = req_chan.valid && req_ready;

   tilt_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW),
      .ADDR_W(SLOT_W)
   ) x_ring (
      .clock  (clock),
      .wr_en  (x_wr_en),
      .wr_addr(slot_ff),
      .wr_data(sample_ff),
      .rd_en  (req_accept),
      .rd_addr(slot_ff),
      .rd_data(x_rd_data)
   );

   tilt_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW),
      .ADDR_W(SLOT_W)
   ) y_ring (
      .clock  (clock),
      .wr_en  (y_wr_en),
      .wr_addr(slot_ff),
      .wr_data(sample_ff),
      .rd_en  (req_accept),
      .rd_addr(slot_ff),
      .rd_data(y_rd_data)
   );

   // An entry never written since reset reads as zero.
   assign old_x = x_vld_ff[slot_ff] ? x_rd_data : '0;
   assign old_y = y_vld_ff[slot_ff] ? y_rd_data : '0;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (kind_ff == AXIS_Y && slot_ff == SLOT_LAST) begin
               state_in = ST_SETUP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SETUP: begin
            state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_ready = 1'b0;
      x_wr_en   = 1'b0;
      y_wr_en   = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_UPDATE: begin
            x_wr_en = (kind_ff == AXIS_X);
            y_wr_en = (kind_ff == AXIS_Y);
         end
         ST_SETUP, ST_ROTATE: begin
         end
         ST_FINISH: begin
            load_rsp = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
         end
      endcase
   end

   // Differences against the zero-tilt sum, pre-scaled for the CORDIC.
   assign num_diff = $signed({1'b0, center_ff}) - $signed({1'b0, x_sum_ff});
   assign den_diff = $signed({1'b0, center_ff}) - $signed({1'b0, y_sum_ff});
   assign num_wide = CORDIC_W'(num_diff) <<< PRESHIFT;
   assign den_wide = CORDIC_W'(den_diff) <<< PRESHIFT;

   // One vectoring step per cycle; arithmetic shifts round toward minus infinity.
   assign x_shift    = cx_ff >>> step_ff;
   assign y_shift    = cy_ff >>> step_ff;
   assign y_positive = !cy_ff[CORDIC_W-1] && (cy_ff != '0);

   // Accumulator is in 1/2048 degree; round halves away from zero to 1/128 degree.
   always_comb begin
      acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      q_mag   = (acc_mag + ACC_W'(1 << (ROUND_BITS - 1))) >> ROUND_BITS;
      if (q_mag > ACC_W'(ANGLE_LIMIT)) begin
         q_sat = ANGLE_W'(ANGLE_LIMIT);
      end else begin
         q_sat = q_mag[ANGLE_W-1:0];
      end
      if (zero_ff) begin
         angle_rounded = '0;
      end else if (acc_ff[ACC_W-1]) begin
         angle_rounded = -$signed(q_sat);
      end else begin
         angle_rounded = $signed(q_sat);
      end
   end

   // Datapath next values.
   always_comb begin
      slot_in      = slot_ff;
      x_sum_in     = x_sum_ff;
      y_sum_in     = y_sum_ff;
      x_vld_in     = x_vld_ff;
      y_vld_in     = y_vld_ff;
      kind_in      = kind_ff;
      sample_in    = sample_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      zero_in      = zero_ff;
      angle_in     = angle_ff;
      center_in    = center_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_chan.valid) begin
         center_in = csr_chan.center_offset;
      end

      if (req_accept) begin
         kind_in   = req_chan.req_type;
         sample_in = req_chan.sample;
      end

      if (state_ff == ST_UPDATE) begin
         if (kind_ff == AXIS_X) begin
            x_sum_in          = x_sum_ff - SUM_W'(old_x) + SUM_W'(sample_ff);
            x_vld_in[slot_ff] = 1'b1;
         end else begin
            y_sum_in          = y_sum_ff - SUM_W'(old_y) + SUM_W'(sample_ff);
            y_vld_in[slot_ff] = 1'b1;
            slot_in           = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
         end
      end

      if (state_ff == ST_SETUP) begin
         // Pre-rotate by a quarter turn so the x component is non-negative.
         zero_in = (num_diff == '0) && (den_diff == '0);
         step_in = '0;
         if (!num_diff[DIFF_W-1]) begin
            cx_in  = num_wide;
            cy_in  = -den_wide;
            acc_in = QUARTER_TURN;
         end else begin
            cx_in  = -num_wide;
            cy_in  = den_wide;
            acc_in = -QUARTER_TURN;
         end
      end

      if (state_ff == ST_ROTATE) begin
         step_in = step_ff + STEP_W'(1);
         if (y_positive) begin
            cx_in  = cx_ff + y_shift;
            cy_in  = cy_ff - x_shift;
            acc_in = acc_ff + atan_entry(step_ff);
         end else begin
            cx_in  = cx_ff - y_shift;
            cy_in  = cy_ff + x_shift;
            acc_in = acc_ff - atan_entry(step_ff);
         end
      end

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         angle_in     = angle_rounded;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         x_sum_ff     <= '0;
         y_sum_ff     <= '0;
         x_vld_ff     <= '0;
         y_vld_ff     <= '0;
         center_ff    <= CENTER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         x_sum_ff     <= x_sum_in;
         y_sum_ff     <= y_sum_in;
         x_vld_ff     <= x_vld_in;
         y_vld_ff     <= y_vld_in;
         center_ff    <= center_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff   <= kind_in;
      sample_ff <= sample_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      acc_ff    <= acc_in;
      step_ff   <= step_in;
      zero_ff   <= zero_in;
      angle_ff  <= angle_in;
   end

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.angle = angle_ff;
   assign csr_chan.ready = 1'b1;

   // The slot index never leaves the ring.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_LAST)
      else $error("slot index beyond ring depth");

   // An accepted sample is followed by its ring read-modify-write.
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_UPDATE)
      else $error("accepted sample not followed by ring update");

   // The last CORDIC step hands over to rounding.
   a_cordic_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE && step_ff == STEP_LAST) |=> state_ff == ST_FINISH)
      else $error("CORDIC pass did not end after its last step");

   // A delivered angle is always within the half-turn limit.
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (angle_ff <= ANGLE_W'(ANGLE_LIMIT)
                        && angle_ff >= -ANGLE_W'(ANGLE_LIMIT)))
      else $error("angle outside the half-turn limit");

   // A window wrap starts a CORDIC pass.
   a_wrap_setup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && kind_ff == AXIS_Y && slot_ff == SLOT_LAST)
      |=> (state_ff == ST_SETUP && slot_ff == '0))
      else $error("window wrap did not start an angle computation");

endmodule

// File: rtl/core/tilt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the per-axis sample rings.
`timescale 1ns / 1ps

module tilt_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 25,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
